// File: rtl/core/uart_16550_register_model_assert.svh
// Assertion macros for the UART register model.
`ifndef UART_16550_REGISTER_MODEL_ASSERT_SVH
`define UART_16550_REGISTER_MODEL_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define UART_RM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define UART_RM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/uart_rm_pkg.sv
// Types and constants shared by the UART register model.
`timescale 1ns / 1ps
`default_nettype none

package uart_rm_pkg;

  // Receive FIFO depth and derived widths.
  localparam int unsigned RxDepth  = 16;
  localparam int unsigned RxPtrW   = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int unsigned RxLevelW = $clog2(RxDepth + 1);

  // Request operation codes. The last code is unused and changes nothing.
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpRecv  = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // Register offsets.
  localparam logic [2:0] RegData  = 3'd0;
  localparam logic [2:0] RegIer   = 3'd1;
  localparam logic [2:0] RegIirFcr = 3'd2;
  localparam logic [2:0] RegLcr   = 3'd3;
  localparam logic [2:0] RegMcr   = 3'd4;
  localparam logic [2:0] RegLsr   = 3'd5;
  localparam logic [2:0] RegMsr   = 3'd6;
  localparam logic [2:0] RegScr   = 3'd7;

  // Interrupt identification codes.
  localparam logic [7:0] IirLineStatus = 8'h06;
  localparam logic [7:0] IirRxData     = 8'h04;
  localparam logic [7:0] IirRxTimeout  = 8'h0C;
  localparam logic [7:0] IirThrEmpty   = 8'h02;
  localparam logic [7:0] IirNone       = 8'h01;

  localparam logic [7:0] LsrReset   = 8'h60;
  localparam logic [7:0] LsrErrMask = 8'h1E;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_index;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/uart_16550_register_model.sv
// Top level of the 16550-style UART register model.
//
//   channel  direction  handshake            payload
//   in       request    in_valid_i/in_stall_o   in_req_i   (op, reg_index, data_byte)
//   out      response   out_valid_o/out_stall_i out_rsp_o  (read_data, irq_line, tx)
//
// Most requests load the response register at the accept edge. A receive buffer read
// that pops a byte goes through the read state, which loads the registered FIFO RAM data.
// The next request is taken once no popped byte is pending and the response register is
// free or is being taken in the same cycle. Reset is asynchronous and active low; the
// FIFO RAM needs no clearing pass since its level counter gates reads.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_16550_register_model_assert.svh"

module uart_16550_register_model (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire uart_rm_pkg::req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output uart_rm_pkg::rsp_t       out_rsp_o
);

  import uart_rm_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic                state_q, state_d;
  logic [RxPtrW-1:0]   wptr_q, wptr_d;
  logic [RxPtrW-1:0]   rptr_q, rptr_d;
  logic [RxLevelW-1:0] level_q, level_d;
  logic [7:0]          lsr_q, lsr_d;
  logic [3:0]          ier_q, ier_d;
  logic [7:0]          lcr_q, lcr_d;
  logic [7:0]          fcr_q, fcr_d;
  logic [4:0]          mcr_q, mcr_d;
  logic [7:0]          scr_q, scr_d;
  logic [7:0]          dll_q, dll_d;
  logic [7:0]          dlm_q, dlm_d;
  logic                irq_q, irq_d;
  logic                out_valid_q;
  rsp_t                out_q, rsp_d;
  logic                rsp_load;
  logic                in_fire;
  logic                pop;
  logic                ram_we, ram_re;
  logic [7:0]          ram_rdata;
  logic [7:0]          iir;
  logic                dlab_sel;

  function automatic logic irq_eval(input logic [3:0] ier, input logic [7:0] lsr);
    irq_eval = (ier[0] && lsr[0]) || (ier[1] && lsr[5]) ||
               (ier[2] && ((lsr & LsrErrMask) != 8'h00));
  endfunction

  function automatic logic [RxPtrW-1:0] ptr_inc(input logic [RxPtrW-1:0] ptr);
    ptr_inc = (ptr == RxPtrW'(RxDepth - 1)) ? '0 : ptr + RxPtrW'(1);
  endfunction

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign dlab_sel   = lcr_q[7] && (in_req_i.reg_index <= RegIer);

  always_comb begin
    priority if (ier_q[2] && ((lsr_q & LsrErrMask) != 8'h00)) begin
      iir = IirLineStatus;
    end else if (ier_q[0] && lsr_q[0]) begin
      iir = IirRxData;
    end else if (ier_q[0] && (level_q != '0)) begin
      iir = IirRxTimeout;
    end else if (ier_q[1] && lsr_q[5]) begin
      iir = IirThrEmpty;
    end else begin
      iir = IirNone;
    end
  end

  always_comb begin
    state_d  = state_q;
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    level_d  = level_q;
    lsr_d    = lsr_q;
    ier_d    = ier_q;
    lcr_d    = lcr_q;
    fcr_d    = fcr_q;
    mcr_d    = mcr_q;
    scr_d    = scr_q;
    dll_d    = dll_q;
    dlm_d    = dlm_q;
    irq_d    = irq_q;
    rsp_d    = '0;
    rsp_load = 1'b0;
    pop      = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    if (state_q == StRead) begin
      // Popped byte arrives from the RAM; reads never move the interrupt line.
      rsp_d.read_data = ram_rdata;
      rsp_d.irq_line  = irq_q;
      rsp_load        = 1'b1;
      state_d         = StIdle;
    end else if (in_fire) begin
      unique case (in_req_i.op)
        OpWrite: begin
          if (dlab_sel) begin
            if (in_req_i.reg_index == RegData) begin
              dll_d = in_req_i.data_byte;
            end else begin
              dlm_d = in_req_i.data_byte;
            end
          end else begin
            unique case (in_req_i.reg_index)
              RegData: begin
                rsp_d.tx_valid = 1'b1;
                rsp_d.tx_byte  = in_req_i.data_byte;
                lsr_d          = lsr_q | LsrReset;
                if (ier_q[1]) begin
                  irq_d = irq_eval(ier_q, lsr_d);
                end
              end
              RegIer: begin
                ier_d = in_req_i.data_byte[3:0];
                irq_d = irq_eval(ier_d, lsr_q);
              end
              RegIirFcr: begin
                fcr_d = in_req_i.data_byte;
                if (in_req_i.data_byte[1]) begin
                  wptr_d   = '0;
                  rptr_d   = '0;
                  level_d  = '0;
                  lsr_d[0] = 1'b0;
                end
              end
              RegLcr: lcr_d = in_req_i.data_byte;
              RegMcr: mcr_d = in_req_i.data_byte[4:0];
              RegScr: scr_d = in_req_i.data_byte;
              default: ;
            endcase
          end
        end
        OpRead: begin
          if (dlab_sel) begin
            rsp_d.read_data = (in_req_i.reg_index == RegData) ? dll_q : dlm_q;
          end else begin
            unique case (in_req_i.reg_index)
              RegData: begin
                if (level_q != '0) begin
                  pop     = 1'b1;
                  ram_re  = 1'b1;
                  rptr_d  = ptr_inc(rptr_q);
                  level_d = level_q - RxLevelW'(1);
                  if (level_d == '0) begin
                    lsr_d[0] = 1'b0;
                  end
                end
              end
              RegIer:    rsp_d.read_data = {4'h0, ier_q};
              RegIirFcr: rsp_d.read_data = iir;
              RegLcr:    rsp_d.read_data = lcr_q;
              RegMcr:    rsp_d.read_data = {3'h0, mcr_q};
              RegLsr:    rsp_d.read_data = lsr_q;
              RegMsr:    rsp_d.read_data = 8'h00;
              RegScr:    rsp_d.read_data = scr_q;
              default: ;
            endcase
          end
        end
        OpRecv: begin
          if (level_q == RxLevelW'(RxDepth)) begin
            lsr_d[1] = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wptr_d   = ptr_inc(wptr_q);
            level_d  = level_q + RxLevelW'(1);
            lsr_d[0] = 1'b1;
            if (ier_q[0]) begin
              irq_d = irq_eval(ier_q, lsr_d);
            end
          end
        end
        default: ;
      endcase
      rsp_d.irq_line = irq_d;
      if (pop) begin
        state_d = StRead;
      end else begin
        rsp_load = 1'b1;
      end
    end
  end

  uart_rm_ram #(
    .Width (8),
    .Depth (RxDepth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (in_req_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wptr_q      <= '0;
      rptr_q      <= '0;
      level_q     <= '0;
      lsr_q       <= LsrReset;
      ier_q       <= '0;
      lcr_q       <= '0;
      fcr_q       <= '0;
      mcr_q       <= '0;
      scr_q       <= '0;
      dll_q       <= 8'h01;
      dlm_q       <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
      lsr_q   <= lsr_d;
      ier_q   <= ier_d;
      lcr_q   <= lcr_d;
      fcr_q   <= fcr_d;
      mcr_q   <= mcr_d;
      scr_q   <= scr_d;
      dll_q   <= dll_d;
      dlm_q   <= dlm_d;
      irq_q   <= irq_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `UART_RM_ASSERT(a_level_bound, level_q <= RxLevelW'(RxDepth), "FIFO level exceeds depth")
  `UART_RM_ASSERT(a_dr_matches_level, lsr_q[0] == (level_q != '0),
                  "Data ready flag disagrees with FIFO level")
  `UART_RM_ASSERT(a_read_slot_free, (state_q == StRead) |-> !out_valid_q,
                  "Response register busy while a popped byte is pending")
  `UART_RM_ASSERT_NEXT(a_pop_waits, in_fire && pop, state_q == StRead && in_stall_o,
                       "Pop did not enter the RAM read cycle")

endmodule

`default_nettype wire

// File: rtl/core/uart_rm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module uart_rm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: bench/uart_16550_register_model_test.sv
// Self-checking testbench for the 16550-style UART register model.
`timescale 1ns / 1ps

class uart_reg_scoreboard;
  localparam logic [7:0] DlabBit = 8'h80;
  localparam logic [7:0] LsrDr   = 8'h01;
  localparam logic [7:0] LsrOe   = 8'h02;
  localparam logic [7:0] LsrThre = 8'h20;
  localparam logic [7:0] LsrTemt = 8'h40;
  localparam logic [7:0] FcrRxClear = 8'h02;

  // Mirror of the register file and the receive FIFO.
  logic [7:0] rx_fifo [uart_rm_pkg::RxDepth];
  logic [uart_rm_pkg::RxPtrW-1:0]   wr_ptr;
  logic [uart_rm_pkg::RxPtrW-1:0]   rd_ptr;
  logic [uart_rm_pkg::RxLevelW-1:0] level;
  logic [7:0] lsr, lcr, fcr, scr, dll, dlm;
  logic [3:0] ier;
  logic [4:0] mcr;
  logic       irq;

  uart_rm_pkg::rsp_t replies_due [$];
  int unsigned mismatches;

  function new();
    wr_ptr = '0;
    rd_ptr = '0;
    level  = '0;
    lsr    = uart_rm_pkg::LsrReset;
    lcr    = 8'h00;
    fcr    = 8'h00;
    scr    = 8'h00;
    dll    = 8'h01;
    dlm    = 8'h00;
    ier    = 4'h0;
    mcr    = 5'h00;
    irq    = 1'b0;
    mismatches = 0;
  endfunction

  function void update_irq();
    irq = (ier[0] && (lsr & LsrDr) != 0) || (ier[1] && (lsr & LsrThre) != 0) ||
          (ier[2] && (lsr & uart_rm_pkg::LsrErrMask) != 0);
  endfunction

  function logic [7:0] iir_value();
    if (ier[2] && (lsr & uart_rm_pkg::LsrErrMask) != 0) return uart_rm_pkg::IirLineStatus;
    if (ier[0] && (lsr & LsrDr) != 0) return uart_rm_pkg::IirRxData;
    if (ier[0] && level != 0) return uart_rm_pkg::IirRxTimeout;
    if (ier[1] && (lsr & LsrThre) != 0) return uart_rm_pkg::IirThrEmpty;
    return uart_rm_pkg::IirNone;
  endfunction

  function void write_register(input logic [2:0] idx, input logic [7:0] v,
                               inout uart_rm_pkg::rsp_t r);
    if ((lcr & DlabBit) != 0 && idx <= uart_rm_pkg::RegIer) begin
      if (idx == uart_rm_pkg::RegData) dll = v;
      else dlm = v;
      return;
    end
    case (idx)
      uart_rm_pkg::RegData: begin
        r.tx_valid = 1'b1;
        r.tx_byte  = v;
        lsr = lsr | LsrThre | LsrTemt;
        if (ier[1]) update_irq();
      end
      uart_rm_pkg::RegIer: begin
        ier = v[3:0];
        update_irq();
      end
      uart_rm_pkg::RegIirFcr: begin
        fcr = v;
        if ((v & FcrRxClear) != 0) begin
          level  = '0;
          wr_ptr = '0;
          rd_ptr = '0;
          lsr    = lsr & ~LsrDr;
        end
      end
      uart_rm_pkg::RegLcr: lcr = v;
      uart_rm_pkg::RegMcr: mcr = v[4:0];
      uart_rm_pkg::RegScr: scr = v;
      default: ;
    endcase
  endfunction

  function logic [7:0] read_register(input logic [2:0] idx);
    logic [7:0] v;
    if ((lcr & DlabBit) != 0 && idx <= uart_rm_pkg::RegIer)
      return (idx == uart_rm_pkg::RegData) ? dll : dlm;
    case (idx)
      uart_rm_pkg::RegData: begin
        if (level == 0) return 8'h00;
        v = rx_fifo[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        level  = level - 1'b1;
        if (level == 0) lsr = lsr & ~LsrDr;
        return v;
      end
      uart_rm_pkg::RegIer:    return {4'h0, ier};
      uart_rm_pkg::RegIirFcr: return iir_value();
      uart_rm_pkg::RegLcr:    return lcr;
      uart_rm_pkg::RegMcr:    return {3'b000, mcr};
      uart_rm_pkg::RegLsr:    return lsr;
      uart_rm_pkg::RegScr:    return scr;
      default:                return 8'h00;
    endcase
  endfunction

  // Advances the mirror by one accepted request and queues the reply it causes.
  function void note_request(input uart_rm_pkg::req_t q);
    uart_rm_pkg::rsp_t want;
    want = '0;
    case (q.op)
      uart_rm_pkg::OpWrite: write_register(q.reg_index, q.data_byte, want);
      uart_rm_pkg::OpRead:  want.read_data = read_register(q.reg_index);
      uart_rm_pkg::OpRecv: begin
        if (level >= uart_rm_pkg::RxDepth) begin
          // A full FIFO drops the byte and leaves the interrupt line alone.
          lsr = lsr | LsrOe;
        end else begin
          rx_fifo[wr_ptr] = q.data_byte;
          wr_ptr = wr_ptr + 1'b1;
          level  = level + 1'b1;
          lsr    = lsr | LsrDr;
          if (ier[0]) update_irq();
        end
      end
      default: ;
    endcase
    want.irq_line = irq;
    replies_due.push_back(want);
  endfunction

  function void check_reply(input uart_rm_pkg::rsp_t got);
    uart_rm_pkg::rsp_t want;
    if (replies_due.size() == 0) begin
      $error("reply with no request pending: %h", got);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (got.read_data !== want.read_data) begin
      $error("read_data expected %h actual %h", want.read_data, got.read_data);
      mismatches++;
    end
    if (got.irq_line !== want.irq_line) begin
      $error("irq_line expected %b actual %b", want.irq_line, got.irq_line);
      mismatches++;
    end
    if (got.tx_valid !== want.tx_valid) begin
      $error("tx_valid expected %b actual %b", want.tx_valid, got.tx_valid);
      mismatches++;
    end
    if (got.tx_byte !== want.tx_byte) begin
      $error("tx_byte expected %h actual %h", want.tx_byte, got.tx_byte);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return replies_due.size();
  endfunction
endclass

module uart_16550_register_model_test;
  import uart_rm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 175;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  req_t in_req = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  uart_reg_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_counted = 0;
  int unsigned cycle_count = 0;

  uart_16550_register_model uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_request(in_req);
      if (out_valid && !out_stall) sb.check_reply(out_rsp);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic req_t mk(input logic [1:0] op, input logic [2:0] idx,
                              input logic [7:0] data);
    req_t r;
    r.op = op;
    r.reg_index = idx;
    r.data_byte = data;
    return r;
  endfunction

  // Presents one request, with a random idle gap ahead of it, and waits for its accept.
  task automatic send(input req_t r);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    if (r.op != OpNone && !(r.op == OpWrite && (r.reg_index == RegLsr || r.reg_index == RegMsr)))
      items_counted++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_episode(input bit heavy);
    int unsigned kind;
    int unsigned n;
    int unsigned m;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2: begin
        // Fill the receive FIFO, then pop it back with status reads mixed in.
        n = heavy ? $urandom_range(1, 20) : $urandom_range(1, 8);
        m = heavy ? $urandom_range(0, n) : $urandom_range(n, n + 2);
        repeat (n) send(mk(OpRecv, 3'($urandom), 8'($urandom)));
        repeat (m) begin
          if ($urandom_range(3) == 0)
            send(mk(OpRead, $urandom_range(1) != 0 ? RegIirFcr : RegLsr, 8'($urandom)));
          else
            send(mk(OpRead, RegData, 8'($urandom)));
        end
      end
      3: begin
        send(mk(OpWrite, RegIer, 8'($urandom)));
        send(mk(OpRead, RegIirFcr, 8'($urandom)));
        send(mk(OpRead, RegLsr, 8'($urandom)));
      end
      4: begin
        send(mk(OpWrite, RegLcr, {1'b1, 7'($urandom)}));
        send(mk(OpWrite, RegData, 8'($urandom)));
        send(mk(OpWrite, RegIer, 8'($urandom)));
        send(mk(OpRead, RegData, 8'($urandom)));
        send(mk(OpRead, RegIer, 8'($urandom)));
        send(mk(OpWrite, RegLcr, {1'b0, 7'($urandom)}));
      end
      5: send(mk(OpWrite, RegIirFcr, 8'($urandom)));
      6: repeat ($urandom_range(1, 3)) send(mk(OpWrite, RegData, 8'($urandom)));
      7, 8: send(mk(2'($urandom), 3'($urandom), 8'($urandom)));
      default: begin
        n = $urandom_range(1) != 0 ? RegMcr : RegScr;
        send(mk(OpWrite, 3'(n), 8'($urandom)));
        send(mk(OpRead, 3'(n), 8'($urandom)));
        send(mk(OpRead, 3'($urandom_range(RegIer, RegLcr)), 8'($urandom)));
      end
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, interrupt sources, divisor latch, and the ignored and odd requests.
    send(mk(OpRead, RegIirFcr, 8'h00));
    send(mk(OpRead, RegLsr, 8'h00));
    send(mk(OpWrite, RegIer, 8'h0F));
    send(mk(OpRead, RegIirFcr, 8'h00));
    send(mk(OpRecv, RegData, 8'h00));
    send(mk(OpRecv, RegScr, 8'hFF));
    send(mk(OpRead, RegIirFcr, 8'h00));
    send(mk(OpRead, RegData, 8'h00));
    send(mk(OpRead, RegData, 8'h00));
    send(mk(OpRead, RegData, 8'hFF));
    send(mk(OpWrite, RegIer, 8'h00));
    send(mk(OpWrite, RegLcr, 8'h80));
    send(mk(OpWrite, RegData, 8'hFF));
    send(mk(OpWrite, RegIer, 8'hA5));
    send(mk(OpRead, RegData, 8'h00));
    send(mk(OpRead, RegIer, 8'h00));
    send(mk(OpWrite, RegLcr, 8'h7F));
    send(mk(OpWrite, RegData, 8'hFF));
    send(mk(OpWrite, RegLsr, 8'hFF));
    send(mk(OpRead, RegMsr, 8'h00));
    send(mk(OpRecv, RegData, 8'h5A));
    send(mk(OpWrite, RegIirFcr, 8'hFF));
    send(mk(OpNone, RegScr, 8'hFF));
    send(mk(OpWrite, RegMcr, 8'hFF));
    send(mk(OpWrite, RegScr, 8'hFF));
    send(mk(OpRead, RegScr, 8'h00));
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      target = items_counted + PhaseItems;
      while (items_counted < target) run_episode(phase == 3);
      // Hold the sender off until every reply of this phase is back.
      drain();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d replies never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
